/* rtl/core/mvpm_pkg.sv */
// Shared types and constants of the multi-voice PCM mixer.
// Used by the channel interfaces and by the mixer top level; no dependencies.
package mvpm_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int FIELD_W   = 24;   // length and fetch position fields
   localparam int CMD_W     = 2;
   localparam int SLOT_W    = 2;
   localparam int VOL_W     = 7;
   localparam int MASK_W    = 4;
   localparam int REPORTED_VOICES = 4;

   typedef logic [CMD_W-1:0]           cmd_type;
   typedef logic [SLOT_W-1:0]          slot_type;
   typedef logic [FIELD_W-1:0]         field_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [VOL_W-1:0]           vol_type;
   typedef logic [MASK_W-1:0]          mask_type;

   localparam cmd_type CMD_TICK     = 2'd0;
   localparam cmd_type CMD_START    = 2'd1;
   localparam cmd_type CMD_STOP     = 2'd2;
   localparam cmd_type CMD_STOP_ALL = 2'd3;

   localparam vol_type FULL_VOLUME = 7'd100;

   // Divide by 100 as multiply by ceil(2^29/100) and shift; exact below 2^22.
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 29;
   localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;

   // APB register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MASTER_VOLUME = 1'b0;

endpackage

/* rtl/core/mvpm_req_if.sv */
// Request channel of the mixer: valid/ready handshake plus command payload.
// Depends on mvpm_pkg.
interface mvpm_req_if;
   import mvpm_pkg::*;

   logic       valid;
   logic       ready;
   cmd_type    cmd;
   slot_type   slot;
   field_type  length;
   logic       loop;
   sample_type sample_0;
   sample_type sample_1;
   sample_type sample_2;
   sample_type sample_3;

   modport source (output valid, output cmd, output slot, output length, output loop,
                   output sample_0, output sample_1, output sample_2, output sample_3,
                   input ready);
   modport sink   (input valid, input cmd, input slot, input length, input loop,
                   input sample_0, input sample_1, input sample_2, input sample_3,
                   output ready);
endinterface

/* rtl/core/mvpm_rsp_if.sv */
// Response channel of the mixer: valid/ready handshake plus result payload.
// Depends on mvpm_pkg.
interface mvpm_rsp_if;
   import mvpm_pkg::*;

   logic       valid;
   logic       ready;
   sample_type mixed_sample;
   mask_type   active_mask;
   slot_type   granted_slot;
   logic       no_free_voice;
   field_type  fetch_pos_0;
   field_type  fetch_pos_1;
   field_type  fetch_pos_2;
   field_type  fetch_pos_3;

   modport source (output valid, output mixed_sample, output active_mask,
                   output granted_slot, output no_free_voice, output fetch_pos_0,
                   output fetch_pos_1, output fetch_pos_2, output fetch_pos_3,
                   input ready);
   modport sink   (input valid, input mixed_sample, input active_mask,
                   input granted_slot, input no_free_voice, input fetch_pos_0,
                   input fetch_pos_1, input fetch_pos_2, input fetch_pos_3,
                   output ready);
endinterface

/* rtl/core/multi_voice_pcm_mixer_top.sv */
// Multi-voice PCM mixer: VOICE_COUNT voices with length, position and repeat flag,
// a saturating mix and a master volume register on an APB port.
// Depends on mvpm_pkg, mvpm_req_if and mvpm_rsp_if.
//
// One request is handled at a time. A tick walks the voices through a single
// shared clamped adder, one voice per cycle, then scales by volume/100 with two
// registered multiplies (volume, then reciprocal of 100) before the done state
// loads the response, and req ready returns the cycle the response is loaded.
// Start, stop and stop-all settle in the accept cycle and go straight to the
// done state. The response register lets a new request be taken while the
// previous response is still waiting. Master volume is register 0 at byte
// address 0; a write keeps its low 7 bits and saturates values above 100 to 100.
module multi_voice_pcm_mixer_top #(
   parameter int VOICE_COUNT   = 4,
   parameter int POSITION_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   mvpm_req_if.sink                          req_chan,
   mvpm_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mvpm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mvpm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mvpm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import mvpm_pkg::*;

   localparam int IDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int MAG_W  = SAMPLE_W + 1;
   localparam int PROD_W = 24;
   localparam int Q_W    = PROD_W + RECIP_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MIX  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic signed [SAMPLE_W:0] SUM_MAX = 17'sd32767;
   localparam logic signed [SAMPLE_W:0] SUM_MIN = -17'sd32768;

   typedef logic [POSITION_BITS-1:0] pos_type;

   // control
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             tick_ff, tick_in;
   vol_type          vol_ff, vol_in;

   // voice state
   logic    active_ff [VOICE_COUNT];
   logic    active_in [VOICE_COUNT];
   pos_type pos_ff [VOICE_COUNT];
   pos_type pos_in [VOICE_COUNT];
   pos_type len_ff [VOICE_COUNT];
   pos_type len_in [VOICE_COUNT];
   logic    rep_ff [VOICE_COUNT];
   logic    rep_in [VOICE_COUNT];

   // datapath
   sample_type           sample_ff [REPORTED_VOICES];
   sample_type           sample_in [REPORTED_VOICES];
   sample_type           mix_ff, mix_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [Q_W-1:0]       q_ff, q_in;
   slot_type             granted_ff, granted_in;
   logic                 nofree_ff, nofree_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type out_mix_ff, out_mix_in;
   mask_type   out_mask_ff, out_mask_in;
   slot_type   out_granted_ff, out_granted_in;
   logic       out_nofree_ff, out_nofree_in;
   field_type  out_pos_ff [REPORTED_VOICES];
   field_type  out_pos_in [REPORTED_VOICES];

   // shared-unit and helper signals
   sample_type               cur_sample;
   pos_type                  next_pos;
   logic signed [SAMPLE_W:0] sum;
   logic [MAG_W-1:0]         mix_ext;
   logic [MAG_W-1:0]         mag;
   logic [MAG_W-1:0]         quot;
   sample_type               scaled;
   logic                     free_found;
   logic [IDX_W-1:0]         free_idx;
   logic                     rep_active [REPORTED_VOICES];
   pos_type                  rep_pos [REPORTED_VOICES];
   sample_type               voice_sample [VOICE_COUNT];

   // APB port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MASTER_VOLUME) ? CSR_DATA_W'(vol_ff) : '0;

   always_comb begin
      vol_in = vol_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_MASTER_VOLUME)) begin
         vol_in = (pwdata[VOL_W-1:0] > FULL_VOLUME) ? FULL_VOLUME : pwdata[VOL_W-1:0];
      end
   end

   // per-voice sample view; voices beyond the reported ones mix silence
   always_comb begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
         if (v < REPORTED_VOICES) begin
            voice_sample[v] = sample_ff[v[1:0]];
         end else begin
            voice_sample[v] = '0;
         end
      end
   end

   // lowest free voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
         if (!active_ff[v]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(v);
         end
      end
   end

   // reported voices view
   always_comb begin
      for (int v = 0; v < REPORTED_VOICES; v++) begin
         rep_active[v] = 1'b0;
         rep_pos[v]    = '0;
      end
      for (int v = 0; v < VOICE_COUNT; v++) begin
         if (v < REPORTED_VOICES) begin
            rep_active[v[1:0]] = active_ff[v];
            rep_pos[v[1:0]]    = pos_ff[v];
         end
      end
   end

   // shared clamped adder and position step
   assign cur_sample = voice_sample[idx_ff];
   assign sum        = {mix_ff[SAMPLE_W-1], mix_ff} + {cur_sample[SAMPLE_W-1], cur_sample};
   assign next_pos   = pos_ff[idx_ff] + pos_type'(1);

   // scaling helpers
   assign mix_ext = {mix_ff[SAMPLE_W-1], mix_ff};
   assign mag     = mix_ff[SAMPLE_W-1] ? (~mix_ext + MAG_W'(1)) : mix_ext;
   assign quot    = q_ff[RECIP_SHIFT +: MAG_W];
   assign scaled  = mix_ff[SAMPLE_W-1] ? SAMPLE_W'(~quot + MAG_W'(1)) : SAMPLE_W'(quot);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      tick_in        = tick_ff;
      mix_in         = mix_ff;
      prod_in        = prod_ff;
      q_in           = q_ff;
      granted_in     = granted_ff;
      nofree_in      = nofree_ff;
      active_in      = active_ff;
      pos_in         = pos_ff;
      len_in         = len_ff;
      rep_in         = rep_ff;
      sample_in      = sample_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_mix_in     = out_mix_ff;
      out_mask_in    = out_mask_ff;
      out_granted_in = out_granted_ff;
      out_nofree_in  = out_nofree_ff;
      out_pos_in     = out_pos_ff;

      req_chan.ready = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sample_in[0] = req_chan.sample_0;
               sample_in[1] = req_chan.sample_1;
               sample_in[2] = req_chan.sample_2;
               sample_in[3] = req_chan.sample_3;
               tick_in      = (req_chan.cmd == CMD_TICK);
               granted_in   = '0;
               nofree_in    = 1'b0;
               mix_in       = '0;
               idx_in       = '0;
               state_in     = ST_DONE;
               unique case (req_chan.cmd)
                  CMD_TICK: begin
                     state_in = ST_MIX;
                  end
                  CMD_START: begin
                     if (free_found) begin
                        active_in[free_idx] = 1'b1;
                        pos_in[free_idx]    = '0;
                        len_in[free_idx]    = POSITION_BITS'(req_chan.length);
                        rep_in[free_idx]    = req_chan.loop;
                        granted_in          = SLOT_W'(free_idx);
                     end else begin
                        nofree_in = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     for (int v = 0; v < VOICE_COUNT; v++) begin
                        if (32'(req_chan.slot) == v) begin
                           active_in[v] = 1'b0;
                           pos_in[v]    = '0;
                        end
                     end
                  end
                  CMD_STOP_ALL: begin
                     for (int v = 0; v < VOICE_COUNT; v++) begin
                        active_in[v] = 1'b0;
                        pos_in[v]    = '0;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MIX: begin
            if (active_ff[idx_ff]) begin
               if (pos_ff[idx_ff] >= len_ff[idx_ff]) begin
                  // zero length: contribute nothing, free unless repeating
                  if (!rep_ff[idx_ff]) begin
                     active_in[idx_ff] = 1'b0;
                     pos_in[idx_ff]    = '0;
                  end
               end else begin
                  if (sum > SUM_MAX) begin
                     mix_in = SUM_MAX[SAMPLE_W-1:0];
                  end else if (sum < SUM_MIN) begin
                     mix_in = SUM_MIN[SAMPLE_W-1:0];
                  end else begin
                     mix_in = sum[SAMPLE_W-1:0];
                  end
                  if (next_pos >= len_ff[idx_ff]) begin
                     pos_in[idx_ff] = '0;
                     if (!rep_ff[idx_ff]) begin
                        active_in[idx_ff] = 1'b0;
                     end
                  end else begin
                     pos_in[idx_ff] = next_pos;
                  end
               end
            end
            if (idx_ff == IDX_W'(VOICE_COUNT - 1)) begin
               state_in = ST_MUL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mag) * PROD_W'(vol_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q_in     = Q_W'(prod_ff) * Q_W'(RECIP_100);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               out_mix_in     = tick_ff ? scaled : '0;
               out_granted_in = granted_ff;
               out_nofree_in  = nofree_ff;
               for (int v = 0; v < REPORTED_VOICES; v++) begin
                  out_mask_in[v] = rep_active[v];
                  out_pos_in[v]  = rep_active[v] ? FIELD_W'(rep_pos[v]) : '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         tick_ff      <= 1'b0;
         vol_ff       <= FULL_VOLUME;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            active_ff[v] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         vol_ff       <= vol_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      len_ff         <= len_in;
      rep_ff         <= rep_in;
      sample_ff      <= sample_in;
      mix_ff         <= mix_in;
      prod_ff        <= prod_in;
      q_ff           <= q_in;
      granted_ff     <= granted_in;
      nofree_ff      <= nofree_in;
      out_mix_ff     <= out_mix_in;
      out_mask_ff    <= out_mask_in;
      out_granted_ff <= out_granted_in;
      out_nofree_ff  <= out_nofree_in;
      out_pos_ff     <= out_pos_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.mixed_sample  = out_mix_ff;
   assign rsp_chan.active_mask   = out_mask_ff;
   assign rsp_chan.granted_slot  = out_granted_ff;
   assign rsp_chan.no_free_voice = out_nofree_ff;
   assign rsp_chan.fetch_pos_0   = out_pos_ff[0];
   assign rsp_chan.fetch_pos_1   = out_pos_ff[1];
   assign rsp_chan.fetch_pos_2   = out_pos_ff[2];
   assign rsp_chan.fetch_pos_3   = out_pos_ff[3];

endmodule
